### src/asf_pkg.sv
// shared types and constants for the adts frame splitter
// no dependencies; imported by every module of the block
package asf_pkg;

    // record queue between the classifier and the emitter, depth must be a power of two
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QLVL_W = $clog2(QDEPTH + 1);

    localparam int OUT_TDATA_W = 56;

    localparam logic [1:0] KIND_SKIP  = 2'd0;
    localparam logic [1:0] KIND_FRAME = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_TRUNC_HDR = 3'd1;
    localparam logic [2:0] STS_TRUNC_FRM = 3'd2;
    localparam logic [2:0] STS_BAD_SFI   = 3'd3;
    localparam logic [2:0] STS_BAD_LEN   = 3'd4;

    localparam logic [7:0]  SYNC_BYTE     = 8'hFF;
    localparam logic [3:0]  SYNC_NIBBLE   = 4'hF;
    localparam logic [12:0] HDR_LEN_NOCRC = 13'd7;
    localparam logic [12:0] HDR_LEN_CRC   = 13'd9;
    localparam logic [3:0]  SFI_LIMIT     = 4'd11;

    localparam logic [12:0] POS_BYTE2 = 13'd2;
    localparam logic [12:0] POS_BYTE3 = 13'd3;
    localparam logic [12:0] POS_BYTE4 = 13'd4;
    localparam logic [12:0] POS_BYTE5 = 13'd5;
    localparam logic [12:0] POS_BODY  = 13'd6;

    typedef struct packed {
        logic [7:0]  data;
        logic [1:0]  kind;
        logic        start;
        logic        fin;
        logic [2:0]  status;
        logic        hdr_ok;
        logic [15:0] hdr;
        logic [12:0] len;
        logic        last;
    } asf_rec_t;

    typedef struct packed {
        logic [1:0] cnt;
        asf_rec_t   rec0;
        asf_rec_t   rec1;
    } asf_push_t;

endpackage

### src/asf_classifier.sv
// front part: accepts stream bytes, finds the syncword, counts out frames
// and pushes up to two result records per transfer; depends on asf_pkg
module asf_classifier (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [7:0]        in_byte,
    input  logic              in_eos,
    input  logic              room,
    output asf_pkg::asf_push_t push
);
    import asf_pkg::*;

    typedef enum logic [1:0] {
        ST_HUNT  = 2'b01,
        ST_FRAME = 2'b10
    } asf_state_t;

    asf_state_t  st_reg, st_next, st_c;
    logic [7:0]  held_reg, held_next;
    logic        hv_reg, hv_next;
    logic [12:0] pos_reg, pos_next, pos_c, pos_inc;
    logic [12:0] len_reg, len_next, len_c;
    logic [15:0] hdr_reg, hdr_next, hdr_c;
    logic        crc_reg, crc_next, crc_c;
    logic [12:0] hdr_size, hdr_size_c;
    logic        accept;
    asf_rec_t    rec_c, rec_end;

    assign accept   = in_valid && room;
    assign hdr_size = crc_reg ? HDR_LEN_NOCRC : HDR_LEN_CRC;
    assign pos_inc  = pos_reg + 13'd1;

    // classification of the held byte, using the incoming byte as lookahead
    always_comb
    begin
        st_c  = st_reg;
        pos_c = pos_reg;
        len_c = len_reg;
        hdr_c = hdr_reg;
        crc_c = crc_reg;
        rec_c        = '0;
        rec_c.data   = held_reg;
        rec_c.last   = !in_eos;
        if (st_reg == ST_HUNT)
        begin
            if (!in_eos && held_reg == SYNC_BYTE && in_byte[7:4] == SYNC_NIBBLE)
            begin
                st_c        = ST_FRAME;
                pos_c       = 13'd1;
                crc_c       = in_byte[0];
                len_c       = '0;
                hdr_c       = '0;
                rec_c.kind  = KIND_FRAME;
                rec_c.start = 1'b1;
            end
            else
            begin
                rec_c.kind = KIND_SKIP;
            end
        end
        else
        begin
            rec_c.kind = KIND_FRAME;
            case (pos_reg)
                POS_BYTE2: hdr_c = {held_reg, hdr_reg[7:0]};
                POS_BYTE3:
                begin
                    hdr_c = {hdr_reg[15:8], held_reg};
                    len_c = {held_reg[1:0], 11'd0};
                end
                POS_BYTE4: len_c = len_reg | {2'd0, held_reg, 3'd0};
                POS_BYTE5: len_c = len_reg | {10'd0, held_reg[7:5]};
                default:   len_c = len_reg;
            endcase
            rec_c.hdr = hdr_c;
            rec_c.len = len_c;
            if (pos_reg == POS_BYTE5 && len_c < hdr_size)
            begin
                st_c         = ST_HUNT;
                pos_c        = '0;
                rec_c.fin    = 1'b1;
                rec_c.status = STS_BAD_LEN;
                rec_c.hdr_ok = 1'b1;
            end
            else if (pos_reg >= POS_BODY && pos_inc == len_reg)
            begin
                st_c         = ST_HUNT;
                pos_c        = '0;
                rec_c.fin    = 1'b1;
                rec_c.status = (hdr_c[13:10] >= SFI_LIMIT) ? STS_BAD_SFI : STS_OK;
                rec_c.hdr_ok = 1'b1;
            end
            else
            begin
                pos_c = pos_inc;
            end
        end
        if (!rec_c.hdr_ok)
        begin
            rec_c.hdr = '0;
            rec_c.len = '0;
        end
    end

    // end marker status looks at the state left after the held byte
    always_comb
    begin
        rec_end      = '0;
        rec_end.kind = KIND_END;
        rec_end.last = 1'b1;
        hdr_size_c   = crc_c ? HDR_LEN_NOCRC : HDR_LEN_CRC;
        if (hv_reg && st_c == ST_FRAME)
        begin
            rec_end.status = (pos_c < hdr_size_c) ? STS_TRUNC_HDR : STS_TRUNC_FRM;
        end
        else if (!hv_reg && st_reg == ST_FRAME)
        begin
            rec_end.status = (pos_reg < hdr_size) ? STS_TRUNC_HDR : STS_TRUNC_FRM;
        end
    end

    always_comb
    begin
        st_next   = st_reg;
        pos_next  = pos_reg;
        len_next  = len_reg;
        hdr_next  = hdr_reg;
        crc_next  = crc_reg;
        held_next = held_reg;
        hv_next   = hv_reg;
        push      = '0;
        if (accept)
        begin
            if (!in_eos)
            begin
                if (hv_reg)
                begin
                    st_next   = st_c;
                    pos_next  = pos_c;
                    len_next  = len_c;
                    hdr_next  = hdr_c;
                    crc_next  = crc_c;
                    push.cnt  = 2'd1;
                    push.rec0 = rec_c;
                end
                held_next = in_byte;
                hv_next   = 1'b1;
            end
            else
            begin
                push.cnt  = hv_reg ? 2'd2 : 2'd1;
                push.rec0 = hv_reg ? rec_c : rec_end;
                push.rec1 = rec_end;
                st_next   = ST_HUNT;
                pos_next  = '0;
                len_next  = '0;
                hdr_next  = '0;
                crc_next  = 1'b0;
                held_next = '0;
                hv_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_HUNT;
            pos_reg  <= '0;
            len_reg  <= '0;
            hdr_reg  <= '0;
            crc_reg  <= 1'b0;
            held_reg <= '0;
            hv_reg   <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            pos_reg  <= pos_next;
            len_reg  <= len_next;
            hdr_reg  <= hdr_next;
            crc_reg  <= crc_next;
            held_reg <= held_next;
            hv_reg   <= hv_next;
        end
    end

endmodule

### src/asf_queue.sv
// record queue between classifier and emitter: two writes, one read per cycle
// depends on asf_pkg
module asf_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  asf_pkg::asf_push_t          push,
    input  logic                        pop,
    output logic                        q_valid,
    output asf_pkg::asf_rec_t           q_rec,
    output logic [asf_pkg::QLVL_W-1:0]  level
);
    import asf_pkg::*;

    asf_rec_t            mem [QDEPTH];
    logic [QPTR_W-1:0]   wptr_reg, wptr_next;
    logic [QPTR_W-1:0]   rptr_reg, rptr_next;
    logic [QLVL_W-1:0]   lvl_reg, lvl_next;
    logic [QPTR_W-1:0]   wptr_plus1;
    logic                do_pop;

    assign do_pop     = pop && (lvl_reg != '0);
    assign wptr_plus1 = wptr_reg + QPTR_W'(1);
    assign wptr_next  = wptr_reg + QPTR_W'(push.cnt);
    assign rptr_next  = rptr_reg + QPTR_W'(do_pop);
    assign lvl_next   = lvl_reg + QLVL_W'(push.cnt) - QLVL_W'(do_pop);

    assign q_valid = (lvl_reg != '0);
    assign q_rec   = mem[rptr_reg];
    assign level   = lvl_reg;

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            mem[wptr_reg] <= push.rec0;
        end
        if (push.cnt == 2'd2)
        begin
            mem[wptr_plus1] <= push.rec1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            lvl_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            lvl_reg  <= lvl_next;
        end
    end

endmodule

### src/asf_emitter.sv
// back part: takes records from the queue, expands the header fields and
// the audio specific config word, and holds them in the output register; depends on asf_pkg
module asf_emitter (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_valid,
    input  asf_pkg::asf_rec_t                q_rec,
    output logic                             pop,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [asf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic [1:0]                       m_axis_tuser,
    output logic                             m_axis_tlast
);
    import asf_pkg::*;

    logic                   vld_reg;
    logic [OUT_TDATA_W-1:0] data_reg, data_next;
    logic [1:0]             user_reg;
    logic                   last_reg;
    logic [2:0]             aot;
    logic [3:0]             sfi;
    logic [2:0]             chan;
    logic [15:0]            asc;

    assign pop = q_valid && (!vld_reg || m_axis_tready);

    always_comb
    begin
        aot  = {1'b0, q_rec.hdr[15:14]} + 3'd1;
        sfi  = q_rec.hdr[13:10];
        chan = {q_rec.hdr[8], q_rec.hdr[7:6]};
        asc  = {2'b00, aot, sfi[3:1], sfi[0], 1'b0, chan, 3'b000};
        if (!q_rec.hdr_ok)
        begin
            aot  = '0;
            sfi  = '0;
            chan = '0;
            asc  = '0;
        end
        data_next = {4'd0, asc, chan, sfi, aot, q_rec.len, q_rec.status,
                     q_rec.fin, q_rec.start, q_rec.data};
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= data_next;
            user_reg <= q_rec.kind;
            last_reg <= q_rec.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (pop)
        begin
            vld_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            vld_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = vld_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tuser  = user_reg;
    assign m_axis_tlast  = last_reg;

endmodule

### src/adts_frame_splitter_top.sv
// adts frame splitter top level: classifier, record queue and emitter
// depends on asf_pkg, asf_classifier, asf_queue, asf_emitter

// Splits an AAC ADTS byte stream into frames. One stream byte is taken per
// cycle; each byte is classified one byte late, since the syncword check needs
// the following byte, so a byte's result appears after the next byte arrives
// and then passes a four-record queue and the output register. A transfer with
// tlast set ends the stream: it gives the held byte (if any) and an end marker,
// so it produces up to two results, draining at one per cycle while the output
// is ready. The input stays ready while at least two queue slots are free,
// which sustains one byte per cycle whenever the output side takes one result
// per cycle. On the last byte of a frame the header fields and the two-byte
// audio specific config word are given; a frame length below the header size
// ends the frame early with a bad-length status and hunting resumes.
module adts_frame_splitter_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,   // stream_byte
    input  logic                             s_axis_tlast,   // stream_end
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // out_byte, frame_start, frame_end, status, frame_length, object_type,
    // rate_index, channel_mode, config_word, 4 zero bits
    output logic [asf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic [1:0]                       m_axis_tuser,   // byte_kind
    output logic                             m_axis_tlast    // last
);
    import asf_pkg::*;

    asf_push_t          push;
    logic               pop;
    logic               q_valid;
    asf_rec_t           q_rec;
    logic [QLVL_W-1:0]  level;
    logic               room;

    assign room          = (level <= QLVL_W'(QDEPTH - 2));
    assign s_axis_tready = room;

    asf_classifier u_classifier (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_byte  (s_axis_tdata),
        .in_eos   (s_axis_tlast),
        .room     (room),
        .push     (push)
    );

    asf_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .pop     (pop),
        .q_valid (q_valid),
        .q_rec   (q_rec),
        .level   (level)
    );

    asf_emitter u_emitter (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_rec         (q_rec),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // queue never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        level <= QLVL_W'(QDEPTH))
        else $error("record queue overflow");

    // end marker always closes the results of its transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_END |-> m_axis_tlast)
        else $error("end marker without tlast");

    // a frame start is a frame byte and never also a frame end
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tuser == KIND_FRAME && !m_axis_tdata[9])
        else $error("bad frame start marking");

    // nonzero status only on a frame end or the end marker
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[12:10] != STS_OK
            |-> m_axis_tdata[9] || m_axis_tuser == KIND_END)
        else $error("status on a plain byte");

endmodule
